// ===== rtl/core/nnpr_pkg.sv =====
package nnpr_pkg;

    localparam int MAX_WIDTH      = 4096;
    localparam int MAX_HEIGHT     = 4096;
    localparam int TRIG_FRAC_BITS = 14;

    localparam int COORD_W    = 12;
    localparam int PIX_W      = 32;
    localparam int ADDR_W     = 24;
    localparam int DIM_W      = 13;
    localparam int TRIG_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // arithmetic widths along the rotation path
    localparam int DELTA_W = COORD_W + 1;                 // signed offset from centre
    localparam int PROD_W  = TRIG_W + DELTA_W;            // one trig product
    localparam int SUM_W   = PROD_W + 1;                  // sum of two products
    localparam int RND_W   = SUM_W + 1 - TRIG_FRAC_BITS;  // rounded magnitude
    localparam int POS_W   = RND_W + 2;                   // signed position after centre add

    localparam int N_STAGES = 8;

    localparam int IN_TDATA_W  = ((2 * COORD_W + PIX_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * COORD_W + ADDR_W + PIX_W + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_COS_ANGLE    = 2'd2,
        CFG_SIN_ANGLE    = 2'd3
    } t_cfg_idx;

    // frame geometry and trig values as the datapath sees them
    typedef struct packed {
        logic        [DIM_W-1:0]   width;   // clamped to the maximum
        logic        [DIM_W-1:0]   height;  // clamped to the maximum
        logic        [COORD_W-1:0] cx;
        logic        [COORD_W-1:0] cy;
        logic signed [TRIG_W-1:0]  cos_a;
        logic signed [TRIG_W-1:0]  sin_a;
    } t_geom;

endpackage

// ===== rtl/core/nnpr_pipe.sv =====
module nnpr_pipe
    import nnpr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_geom               i_geom,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [COORD_W-1:0]  i_src_x,
    input  logic [COORD_W-1:0]  i_src_y,
    input  logic [PIX_W-1:0]    i_src_pixel,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_write_enable,
    output logic [COORD_W-1:0]  o_dest_x,
    output logic [COORD_W-1:0]  o_dest_y,
    output logic [ADDR_W-1:0]   o_dest_addr,
    output logic [PIX_W-1:0]    o_dest_pixel
);

    localparam logic [SUM_W:0] HALF = (SUM_W+1)'(1) << (TRIG_FRAC_BITS - 1);

    logic [N_STAGES-1:0] r_vld;
    logic [N_STAGES-1:0] w_en;
    logic [PIX_W-1:0]    r_pix [N_STAGES];

    // stage 1: offsets
    logic signed [DELTA_W-1:0] r_dx, r_dy;
    // stage 2: products
    logic signed [PROD_W-1:0]  r_pcx, r_psx, r_pcy, r_psy;
    // stage 3: sums
    logic signed [SUM_W-1:0]   r_sumx, r_sumy;
    // stage 4: sign and magnitude
    logic                      r4_negx, r4_negy;
    logic        [SUM_W-1:0]   r_magx, r_magy;
    // stage 5: rounded magnitude
    logic                      r5_negx, r5_negy;
    logic        [RND_W-1:0]   r_rndx, r_rndy;
    // stage 6: position and bound test
    logic                      r6_we;
    logic        [COORD_W-1:0] r6_x, r6_y;
    // stage 7: row offset
    logic                      r7_we;
    logic        [COORD_W-1:0] r7_x, r7_y;
    logic        [ADDR_W-1:0]  r7_row;
    // stage 8: output register
    logic                      r8_we;
    logic        [COORD_W-1:0] r8_x, r8_y;
    logic        [ADDR_W-1:0]  r8_addr;

    logic signed [PROD_W-1:0]  n_pcx, n_psx, n_pcy, n_psy;
    logic        [SUM_W:0]     n_tx, n_ty;
    logic signed [POS_W-1:0]   n_posx, n_posy, w_cx, w_cy, w_rx, w_ry;
    logic                      n_inside;

    // a stage moves when it is empty or its successor moves
    always_comb begin
        w_en[N_STAGES-1] = !r_vld[N_STAGES-1] || i_ready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < N_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_pix[0] <= i_src_pixel;
        end
        for (int k = 1; k < N_STAGES; k++) begin
            if (w_en[k]) begin
                r_pix[k] <= r_pix[k-1];
            end
        end
    end

    always_comb begin
        n_pcx = $signed(i_geom.cos_a) * r_dx;
        n_psx = $signed(i_geom.sin_a) * r_dx;
        n_pcy = $signed(i_geom.cos_a) * r_dy;
        n_psy = $signed(i_geom.sin_a) * r_dy;
        n_tx  = {1'b0, r_magx} + HALF;
        n_ty  = {1'b0, r_magy} + HALF;
        w_cx  = $signed({(POS_W-COORD_W)'(0), i_geom.cx});
        w_cy  = $signed({(POS_W-COORD_W)'(0), i_geom.cy});
        w_rx  = $signed({(POS_W-RND_W)'(0), r_rndx});
        w_ry  = $signed({(POS_W-RND_W)'(0), r_rndy});
        n_posx = r5_negx ? (w_cx - w_rx) : (w_cx + w_rx);
        n_posy = r5_negy ? (w_cy - w_ry) : (w_cy + w_ry);
        n_inside = !n_posx[POS_W-1] && !n_posy[POS_W-1]
            && (n_posx < $signed({(POS_W-DIM_W)'(0), i_geom.width}))
            && (n_posy < $signed({(POS_W-DIM_W)'(0), i_geom.height}));
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_dx <= $signed({1'b0, i_src_x}) - $signed({1'b0, i_geom.cx});
            r_dy <= $signed({1'b0, i_src_y}) - $signed({1'b0, i_geom.cy});
        end
        if (w_en[1]) begin
            r_pcx <= n_pcx;
            r_psx <= n_psx;
            r_pcy <= n_pcy;
            r_psy <= n_psy;
        end
        if (w_en[2]) begin
            r_sumx <= $signed({r_pcx[PROD_W-1], r_pcx}) - $signed({r_psy[PROD_W-1], r_psy});
            r_sumy <= $signed({r_psx[PROD_W-1], r_psx}) + $signed({r_pcy[PROD_W-1], r_pcy});
        end
        if (w_en[3]) begin
            r4_negx <= r_sumx[SUM_W-1];
            r4_negy <= r_sumy[SUM_W-1];
            r_magx  <= r_sumx[SUM_W-1] ? SUM_W'(-r_sumx) : SUM_W'(r_sumx);
            r_magy  <= r_sumy[SUM_W-1] ? SUM_W'(-r_sumy) : SUM_W'(r_sumy);
        end
        if (w_en[4]) begin
            r5_negx <= r4_negx;
            r5_negy <= r4_negy;
            r_rndx  <= n_tx[SUM_W:TRIG_FRAC_BITS];
            r_rndy  <= n_ty[SUM_W:TRIG_FRAC_BITS];
        end
        if (w_en[5]) begin
            // dropped writes carry zero coordinates, hence a zero address later
            r6_we <= n_inside;
            r6_x  <= n_inside ? n_posx[COORD_W-1:0] : '0;
            r6_y  <= n_inside ? n_posy[COORD_W-1:0] : '0;
        end
        if (w_en[6]) begin
            r7_we  <= r6_we;
            r7_x   <= r6_x;
            r7_y   <= r6_y;
            r7_row <= ADDR_W'(r6_y * i_geom.width);
        end
        if (w_en[7]) begin
            r8_we   <= r7_we;
            r8_x    <= r7_x;
            r8_y    <= r7_y;
            r8_addr <= r7_row + ADDR_W'(r7_x);
        end
    end

    assign o_valid        = r_vld[N_STAGES-1];
    assign o_write_enable = r8_we;
    assign o_dest_x       = r8_x;
    assign o_dest_y       = r8_y;
    assign o_dest_addr    = r8_addr;
    assign o_dest_pixel   = r_pix[N_STAGES-1];

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_write_enable) |-> (o_dest_x == '0 && o_dest_y == '0
            && o_dest_addr == '0))
        else $error("dropped write with non-zero destination");

    a_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_write_enable) |-> ({1'b0, o_dest_x} < i_geom.width
            && {1'b0, o_dest_y} < i_geom.height))
        else $error("write outside the frame");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted transaction lost at entry");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_dest_addr)
            && $stable(o_write_enable)))
        else $error("stalled result changed");

endmodule

// ===== rtl/core/nearest_neighbor_pixel_rotator_top.sv =====
// Channel   Dir  Handshake                     Payload (low bit first)
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: src_x, src_y, src_pixel
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: dest_x, dest_y, dest_addr, dest_pixel
//                                              tuser: write_enable
// cfg       in   i_cfg_we (no stall)           i_cfg_idx, i_cfg_data
//
// One transaction per clock sustained while m_axis_tready stays high; the path
// runs through the eight register stages (offset, products, sums, magnitude,
// rounding, position/bound, row multiply, address add).
// Reset clears all stage valid bits and loads the default geometry
// (4096 x 4096, cos 1.0, sin 0).
// On a stall each stage holds while its successor is full; empty stages keep
// filling, so the input still takes transactions while a result waits.
module nearest_neighbor_pixel_rotator_top
    import nnpr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // source pixels
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // src_x[11:0], src_y[23:12], src_pixel[55:24]
    // destination writes
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // dest_x[11:0], dest_y[23:12],
                                                   // dest_addr[47:24], dest_pixel[79:48]
    output logic [0:0]             m_axis_tuser    // write_enable[0]
);

    localparam logic [DIM_W-1:0] MAX_W = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H = DIM_W'(MAX_HEIGHT);

    logic        [DIM_W-1:0]  r_width;
    logic        [DIM_W-1:0]  r_height;
    logic signed [TRIG_W-1:0] r_cos;
    logic signed [TRIG_W-1:0] r_sin;

    t_geom                    w_geom;
    logic        [DIM_W-1:0]  w_w, w_h;

    logic                     w_we;
    logic        [COORD_W-1:0] w_dx, w_dy;
    logic        [ADDR_W-1:0] w_addr;
    logic        [PIX_W-1:0]  w_pix;

    // register file; written only while the pipe is empty, which the user must keep to (not enforced here)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= MAX_W;
            r_height <= MAX_H;
            r_cos    <= TRIG_W'(1 << TRIG_FRAC_BITS);
            r_sin    <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_IMAGE_WIDTH: begin
                    r_width <= i_cfg_data[DIM_W-1:0];
                end
                CFG_IMAGE_HEIGHT: begin
                    r_height <= i_cfg_data[DIM_W-1:0];
                end
                CFG_COS_ANGLE: begin
                    r_cos <= $signed(i_cfg_data[TRIG_W-1:0]);
                end
                CFG_SIN_ANGLE: begin
                    r_sin <= $signed(i_cfg_data[TRIG_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // oversized frames behave as the largest frame; centre is the integer half
    always_comb begin
        w_w = (r_width  > MAX_W) ? MAX_W : r_width;
        w_h = (r_height > MAX_H) ? MAX_H : r_height;
        w_geom.width  = w_w;
        w_geom.height = w_h;
        w_geom.cx     = w_w[DIM_W-1:1];
        w_geom.cy     = w_h[DIM_W-1:1];
        w_geom.cos_a  = r_cos;
        w_geom.sin_a  = r_sin;
    end

    nnpr_pipe u_pipe (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_geom         (w_geom),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_src_x        (s_axis_tdata[COORD_W-1:0]),
        .i_src_y        (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .i_src_pixel    (s_axis_tdata[2*COORD_W+PIX_W-1:2*COORD_W]),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_write_enable (w_we),
        .o_dest_x       (w_dx),
        .o_dest_y       (w_dy),
        .o_dest_addr    (w_addr),
        .o_dest_pixel   (w_pix)
    );

    assign m_axis_tdata = OUT_TDATA_W'({w_pix, w_addr, w_dy, w_dx});
    assign m_axis_tuser = w_we;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import nnpr_pkg::*;

    localparam int CLK_PERIOD = 8;
    localparam int SETTLE     = 16;      // pipeline depth plus margin
    localparam int IDLE_PCT   = 13;
    localparam int REPORT_MAX = 10;

    // one destination write as it leaves the block
    typedef struct packed {
        logic               wr_en;
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
        logic [ADDR_W-1:0]  dest_addr;
        logic [PIX_W-1:0]   pixel;
    } t_dest_write;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;

    // our own copy of the geometry registers
    logic        [DIM_W-1:0]  frame_w;
    logic        [DIM_W-1:0]  frame_h;
    logic signed [TRIG_W-1:0] cos_q;
    logic signed [TRIG_W-1:0] sin_q;

    t_dest_write expected_writes[$];
    int          mismatches  = 0;
    bit          steady_flow = 1'b0;   // both sides run without gaps
    int          tready_hold = 0;      // cycles the receiver still holds off

    nearest_neighbor_pixel_rotator_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // hard stop in case the pipeline locks up
    initial begin
        #(CLK_PERIOD * 400000);
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // divide by 2^frac, halves away from zero
    function automatic longint round_q(input longint p);
        longint m;
        m = (p < 0) ? -p : p;
        m = (m + (longint'(1) << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
        return (p < 0) ? -m : m;
    endfunction

    // rotate one source pixel about the frame centre, forward mapping
    function automatic t_dest_write rotate_pixel(input logic [COORD_W-1:0] sx,
                                                 input logic [COORD_W-1:0] sy,
                                                 input logic [PIX_W-1:0]   pix);
        longint      w, h, cx, cy, dx, dy, c, s, rx, ry, addr;
        t_dest_write res;
        w  = (frame_w > MAX_WIDTH)  ? MAX_WIDTH  : frame_w;
        h  = (frame_h > MAX_HEIGHT) ? MAX_HEIGHT : frame_h;
        cx = w / 2;
        cy = h / 2;
        dx = longint'(sx) - cx;
        dy = longint'(sy) - cy;
        c  = cos_q;
        s  = sin_q;
        rx = round_q(c * dx - s * dy) + cx;
        ry = round_q(s * dx + c * dy) + cy;
        res       = '0;
        res.pixel = pix;
        // out-of-frame writes are dropped with zeroed coordinates
        if (rx >= 0 && rx < w && ry >= 0 && ry < h) begin
            addr          = ry * w + rx;
            res.wr_en     = 1'b1;
            res.dest_x    = rx[COORD_W-1:0];
            res.dest_y    = ry[COORD_W-1:0];
            res.dest_addr = addr[ADDR_W-1:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random gaps, or a counted hold-off when a test asks for one
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (tready_hold > 0) begin
            m_axis_tready <= 1'b0;
            tready_hold    = tready_hold - 1;
        end else begin
            m_axis_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // compare every write transaction with the oldest prediction
    always @(posedge i_clk) begin : check_writes
        t_dest_write got;
        t_dest_write want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.wr_en     = m_axis_tuser[0];
            got.dest_x    = m_axis_tdata[11:0];
            got.dest_y    = m_axis_tdata[23:12];
            got.dest_addr = m_axis_tdata[47:24];
            got.pixel     = m_axis_tdata[79:48];
            if (expected_writes.size() == 0) begin
                if (mismatches < REPORT_MAX)
                    $display("unexpected write: we=%0d x=%0d y=%0d addr=%0d pix=%08h",
                             got.wr_en, got.dest_x, got.dest_y, got.dest_addr, got.pixel);
                mismatches++;
            end else begin
                want = expected_writes.pop_front();
                if (got.wr_en !== want.wr_en || got.dest_x !== want.dest_x ||
                    got.dest_y !== want.dest_y || got.dest_addr !== want.dest_addr ||
                    got.pixel !== want.pixel) begin
                    if (mismatches < REPORT_MAX) begin
                        $display("write mismatch: exp we=%0d x=%0d y=%0d addr=%0d pix=%08h",
                                 want.wr_en, want.dest_x, want.dest_y, want.dest_addr,
                                 want.pixel);
                        $display("                got we=%0d x=%0d y=%0d addr=%0d pix=%08h",
                                 got.wr_en, got.dest_x, got.dest_y, got.dest_addr,
                                 got.pixel);
                    end
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared tasks
    // ------------------------------------------------------------------

    // offer one source pixel; returns at the edge where the transaction goes through
    task automatic send_pixel(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                              input logic [PIX_W-1:0] pix);
        @(negedge i_clk);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pix, sy, sx};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_writes.push_back(rotate_pixel(sx, sy, pix));
    endtask

    // stop offering and let the pipeline drain completely
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_writes.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH:  frame_w = val[DIM_W-1:0];
            CFG_IMAGE_HEIGHT: frame_h = val[DIM_W-1:0];
            CFG_COS_ANGLE:    cos_q   = val;
            CFG_SIN_ANGLE:    sin_q   = val;
            default: ;
        endcase
    endtask

    // only ever reprogrammed with the pipeline empty
    task automatic set_geometry(input int unsigned w, input int unsigned h,
                                input logic signed [TRIG_W-1:0] c,
                                input logic signed [TRIG_W-1:0] s);
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH,  CFG_DATA_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_COS_ANGLE,    c);
        write_reg(CFG_SIN_ANGLE,    s);
    endtask

    // frame sizes biased to small, with the clamp and the empty frame now and then
    function automatic int unsigned pick_dim();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom_range(16, 1);
            4, 5:       return $urandom_range(256, 17);
            6:          return $urandom_range(4096, 1);
            7:          return 4096;
            8:          return $urandom_range(8191, 4097);
            default:    return $urandom_range(3, 0);
        endcase
    endfunction

    // source coordinate, mostly inside the frame, sometimes anywhere
    function automatic logic [COORD_W-1:0] pick_coord(input int unsigned dim);
        int unsigned lim;
        lim = (dim > 4096) ? 4096 : dim;
        if (lim == 0 || $urandom_range(3) == 0)
            return COORD_W'($urandom_range(4095));
        return COORD_W'($urandom_range(lim - 1));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed();
        // reset geometry: identity on 4096 x 4096, corners hit address extremes
        send_pixel(12'd0,    12'd0,    32'h0000_0000);
        send_pixel(12'd4095, 12'd4095, 32'hFFFF_FFFF);
        send_pixel(12'd2048, 12'd2048, 32'hA5A5_5A5A);
        // quarter turn: some corners land one past the edge
        set_geometry(4096, 4096, 16'sd0, 16'sd16384);
        send_pixel(12'd0,    12'd0,    32'h1234_5678);
        send_pixel(12'd4095, 12'd0,    32'h8765_4321);
        send_pixel(12'd0,    12'd4095, 32'h0F0F_F0F0);
        // half scale: products land exactly on .5, both signs
        set_geometry(16, 16, 16'sd8192, 16'sd0);
        send_pixel(12'd9, 12'd9, 32'h0000_0001);
        send_pixel(12'd7, 12'd7, 32'h0000_0002);
        send_pixel(12'd9, 12'd7, 32'h0000_0003);
        set_geometry(16, 16, 16'sd0, 16'sd8192);
        send_pixel(12'd9, 12'd7, 32'h0000_0004);
        send_pixel(12'd7, 12'd9, 32'h0000_0005);
        // identity on a small frame: source outside the frame, edge at width
        set_geometry(16, 16, 16'sd16384, 16'sd0);
        send_pixel(12'd4095, 12'd3,    32'hDEAD_BEEF);
        send_pixel(12'd3,    12'd4095, 32'hCAFE_F00D);
        send_pixel(12'd16,   12'd0,    32'h5555_AAAA);
        send_pixel(12'd15,   12'd15,   32'hAAAA_5555);
        // empty frame: every write dropped
        set_geometry(0, 16, 16'sd16384, 16'sd0);
        send_pixel(12'd0, 12'd0, 32'h1111_1111);
        send_pixel(12'd5, 12'd5, 32'h2222_2222);
        set_geometry(16, 0, 16'sd16384, 16'sd0);
        send_pixel(12'd5, 12'd5, 32'h3333_3333);
        // oversized registers clamp to the maximum frame
        set_geometry(8191, 8191, 16'sd16384, 16'sd0);
        send_pixel(12'd4095, 12'd4095, 32'h4444_4444);
        send_pixel(12'd0,    12'd0,    32'h6666_6666);
        // single-pixel frame
        set_geometry(1, 1, 16'sd16384, 16'sd0);
        send_pixel(12'd0, 12'd0, 32'h7777_7777);
        send_pixel(12'd1, 12'd0, 32'h8888_8888);
        // trig values well past unity, both extremes
        set_geometry(64, 64, 16'sd32767, -16'sd32768);
        send_pixel(12'd40, 12'd20, 32'h9999_9999);
        send_pixel(12'd0,  12'd63, 32'hBBBB_BBBB);
        set_geometry(64, 64, -16'sd32768, 16'sd32767);
        send_pixel(12'd63, 12'd0,  32'hCCCC_CCCC);
    endtask

    task automatic test_random_frames();
        int unsigned             w, h;
        logic signed [TRIG_W-1:0] c, s;
        for (int ph = 0; ph < 8; ph++) begin
            w = pick_dim();
            h = pick_dim();
            case ($urandom_range(7))
                0:       begin c = 16'sd16384;  s = 16'sd0;     end
                1:       begin c = 16'sd0;      s = 16'sd16384; end
                2:       begin c = -16'sd16384; s = 16'sd0;     end
                3:       begin c = 16'sd11585;  s = 16'sd11585; end  // 45 degrees
                4:       begin c = 16'sd14189;  s = 16'sd8192;  end  // 30 degrees
                5:       begin c = 16'sd8192;   s = 16'sd14189; end  // 60 degrees
                6:       begin c = TRIG_W'($urandom); s = TRIG_W'($urandom); end
                default: begin
                    c = TRIG_W'($urandom_range(32768)) - 16'sd16384;
                    s = TRIG_W'($urandom_range(32768)) - 16'sd16384;
                end
            endcase
            if ($urandom_range(1) == 1) s = -s;   // other direction
            set_geometry(w, h, c, s);
            repeat (150)
                send_pixel(pick_coord(w), pick_coord(h), PIX_W'($urandom));
        end
    endtask

    // long stretch at full rate on both sides
    task automatic test_no_idle();
        set_geometry(64, 48, 16'sd14189, -16'sd8192);
        @(posedge i_clk);
        steady_flow = 1'b1;
        repeat (300)
            send_pixel(pick_coord(64), pick_coord(48), PIX_W'($urandom));
        wait_idle();
        @(posedge i_clk);
        steady_flow = 1'b0;
    endtask

    // receiver holds off long enough for the pipeline to fill and stall the input
    task automatic test_backpressure();
        set_geometry(100, 80, 16'sd11585, 16'sd11585);
        @(posedge i_clk);
        steady_flow = 1'b1;
        tready_hold = 300;
        repeat (80)
            send_pixel(pick_coord(100), pick_coord(80), PIX_W'($urandom));
        wait_idle();
        @(posedge i_clk);
        steady_flow = 1'b0;
    endtask

    initial begin
        frame_w = DIM_W'(4096);
        frame_h = DIM_W'(4096);
        cos_q   = 16'sd16384;
        sin_q   = 16'sd0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_frames();
        test_no_idle();
        test_backpressure();
        wait_idle();

        if (mismatches == 0 && expected_writes.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
